[design/gsv_pkg.sv]
// Shared types and codes for the growable stack vector.
package gsv_pkg;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 9;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SET    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FIXED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BOUNDS  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_CAP   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 1'b1;

   localparam logic [COUNT_W-1:0] RESET_INIT_CAP   = 9'd8;
   localparam logic [COUNT_W-1:0] RESET_BLOCK_SIZE = 9'd8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                take_read;
      logic [COUNT_W-1:0]  count;
      logic [COUNT_W-1:0]  capacity;
   } gsv_result_type;

endpackage

[design/gsv_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module gsv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         store_ff[addr] <= wdata;
      end
      if (en && !we) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/gsv_ctrl.sv]
// Size and capacity bookkeeping, configuration registers and memory command decode.
module gsv_ctrl
   import gsv_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [CSR_IDX_W-1:0]                    csr_index,
   input  logic [COUNT_W-1:0]                      csr_data,
   input  logic                                    op_accept,
   input  logic [KIND_W-1:0]                       op_kind,
   input  logic [INDEX_W-1:0]                      op_index,
   input  logic [VALUE_W-1:0]                      op_value,
   output logic                                    mem_en,
   output logic                                    mem_we,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_addr,
   output logic [VALUE_W-1:0]                      mem_wdata,
   output gsv_result_type                          result
);

   localparam int unsigned AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned XW = (CW > COUNT_W ? CW : COUNT_W) + 2;
   localparam int unsigned IW = AW > INDEX_W ? AW : INDEX_W;
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

   logic [CW-1:0]      size_ff, size_in;
   logic [CW-1:0]      cap_ff, cap_in;
   logic [COUNT_W-1:0] init_ff, init_in;
   logic [COUNT_W-1:0] blk_ff, blk_in;

   logic [XW-1:0] size_x, cap_x, blk_x, init_x, floor_x, grown_x, new_size_x, new_cap_x;
   logic [IW-1:0] index_w;
   logic [CW-1:0] size_dec;
   logic [STATUS_W-1:0] status;
   logic take_read;

   assign size_x   = XW'(size_ff);
   assign cap_x    = XW'(cap_ff);
   assign blk_x    = XW'(blk_ff);
   assign init_x   = XW'(init_ff);
   assign floor_x  = (init_x > DEPTH_X) ? DEPTH_X : init_x;
   assign grown_x  = cap_x + blk_x;
   assign index_w  = IW'(op_index);
   assign size_dec = size_ff - CW'(1);

   always_comb begin
      status     = ST_OK;
      take_read  = 1'b0;
      new_size_x = size_x;
      new_cap_x  = cap_x;
      mem_en     = 1'b0;
      mem_we     = 1'b0;
      mem_addr   = index_w[AW-1:0];
      mem_wdata  = op_value;
      case (op_kind)
         KIND_APPEND: begin
            if (op_value == '0) begin
               status = ST_INVALID;
            end else if (size_x >= cap_x && blk_x == '0) begin
               status = ST_FIXED;
            end else if (size_x >= cap_x && grown_x > DEPTH_X) begin
               status = ST_ALLOC;
            end else begin
               if (size_x >= cap_x) begin
                  new_cap_x = grown_x;
               end
               if (size_x < DEPTH_X) begin
                  mem_en     = 1'b1;
                  mem_we     = 1'b1;
                  mem_addr   = size_ff[AW-1:0];
                  new_size_x = size_x + XW'(1);
               end else begin
                  status = ST_ALLOC;
               end
            end
         end
         KIND_REMOVE: begin
            if (size_x == '0) begin
               status = ST_EMPTY;
            end else begin
               new_size_x = XW'(size_dec);
               mem_en     = 1'b1;
               mem_addr   = size_dec[AW-1:0];
               take_read  = 1'b1;
               if (blk_x != '0 && cap_x > floor_x &&
                   (cap_x - XW'(size_dec)) >= (blk_x << 1)) begin
                  new_cap_x = cap_x - blk_x;
               end
            end
         end
         KIND_GET: begin
            if (XW'(op_index) >= size_x) begin
               status = ST_BOUNDS;
            end else begin
               mem_en    = 1'b1;
               take_read = 1'b1;
            end
         end
         KIND_SET: begin
            if (XW'(op_index) >= size_x) begin
               status = ST_BOUNDS;
            end else begin
               mem_en = 1'b1;
               mem_we = 1'b1;
            end
         end
         KIND_QUERY: begin
            status = ST_OK;
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
      if (!op_accept) begin
         mem_en = 1'b0;
      end
   end

   always_comb begin
      size_in = size_ff;
      cap_in  = cap_ff;
      init_in = init_ff;
      blk_in  = blk_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INIT_CAP: begin
               init_in = csr_data;
               size_in = '0;
               cap_in  = (XW'(csr_data) > DEPTH_X) ? CW'(DEPTH) : CW'(csr_data);
            end
            CSR_BLOCK_SIZE: begin
               blk_in = csr_data;
            end
            default: begin
               blk_in = blk_ff;
            end
         endcase
      end else if (op_accept) begin
         size_in = new_size_x[CW-1:0];
         cap_in  = new_cap_x[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         cap_ff  <= (XW'(RESET_INIT_CAP) > DEPTH_X) ? CW'(DEPTH) : CW'(RESET_INIT_CAP);
         init_ff <= RESET_INIT_CAP;
         blk_ff  <= RESET_BLOCK_SIZE;
      end else begin
         size_ff <= size_in;
         cap_ff  <= cap_in;
         init_ff <= init_in;
         blk_ff  <= blk_in;
      end
   end

   assign result.status    = status;
   assign result.take_read = take_read;
   assign result.count     = new_size_x[COUNT_W-1:0];
   assign result.capacity  = new_cap_x[COUNT_W-1:0];

endmodule

[design/growable_stack_vector.sv]
// Top level of the growable stack vector: request decode, handle memory and result pipeline.
//
// The block takes one request per cycle while req_stall is low and returns exactly one
// result per request; each result passes through the middle stage and the output register.
// Size and capacity are updated in the cycle the request is taken, so a following request
// sees them at once; the handle store is a single-port RAM with at most one access per
// request and a registered read. A result held by a stall sits in the output register
// while one more request completes into the middle stage; after that the request side is
// stalled. The configuration port is always ready. The user must write it only while no
// request is in flight; the block itself does not enforce this. Handle storage is not cleared
// at reset and needs no clearing pass, since only positions below the element count are ever read.
module growable_stack_vector
   import gsv_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [INDEX_W-1:0]   req_index,
   input  logic [VALUE_W-1:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [VALUE_W-1:0]   rsp_read_value,
   output logic [COUNT_W-1:0]   rsp_element_count,
   output logic [COUNT_W-1:0]   rsp_current_capacity,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]   csr_data
);

   localparam int unsigned AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

   logic              mem_en, mem_we;
   logic [AW-1:0]     mem_addr;
   logic [VALUE_W-1:0] mem_wdata, mem_rdata;
   gsv_result_type    result;

   logic              mid_valid_ff, mid_valid_in;
   gsv_result_type    mid_ff, mid_in;
   logic              out_valid_ff, out_valid_in;
   gsv_result_type    out_ff, out_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;

   logic req_accept, mid_move;

   assign csr_ready  = 1'b1;
   assign mid_move   = mid_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = mid_valid_ff && !mid_move;
   assign req_accept = req_valid && !req_stall;

   gsv_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .op_accept (req_accept),
      .op_kind   (req_kind),
      .op_index  (req_index),
      .op_value  (req_value),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .result    (result)
   );

   gsv_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      mid_valid_in = mid_valid_ff;
      mid_in       = mid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_value_in = out_value_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (mid_move) begin
         out_valid_in = 1'b1;
         out_in       = mid_ff;
         out_value_in = mid_ff.take_read ? mem_rdata : '0;
         mid_valid_in = 1'b0;
      end
      if (req_accept) begin
         mid_valid_in = 1'b1;
         mid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
      mid_ff       <= mid_in;
      out_ff       <= out_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_ff.status;
   assign rsp_read_value       = out_value_ff;
   assign rsp_element_count    = out_ff.count;
   assign rsp_current_capacity = out_ff.capacity;

endmodule

[design/gsv_checker.sv]
// Port-level assertions for the growable stack vector and their binding.
module gsv_port_checks
   import gsv_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [VALUE_W-1:0]  rsp_read_value,
   input logic [COUNT_W-1:0]  rsp_element_count,
   input logic [COUNT_W-1:0]  rsp_current_capacity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_value) && $stable(rsp_element_count))
      else $error("Stalled result changed.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("Failed operation returned a handle.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_INVALID ||
      rsp_status == ST_FIXED || rsp_status == ST_ALLOC ||
      rsp_status == ST_EMPTY || rsp_status == ST_BOUNDS)
      else $error("Unknown status code.");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_count <= rsp_current_capacity)
      else $error("Element count exceeds capacity.");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_element_count == '0)
      else $error("Empty status with elements present.");

endmodule

bind growable_stack_vector gsv_port_checks u_gsv_port_checks (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_status           (rsp_status),
   .rsp_read_value       (rsp_read_value),
   .rsp_element_count    (rsp_element_count),
   .rsp_current_capacity (rsp_current_capacity)
);

[tb/gsv_checker.sv]
// Checker for the growable stack vector: predicts each result and compares it with the block.
module gsv_checker
   import gsv_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [INDEX_W-1:0]   req_index,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic [VALUE_W-1:0]   rsp_read_value,
   input  logic [COUNT_W-1:0]   rsp_element_count,
   input  logic [COUNT_W-1:0]   rsp_current_capacity,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]   csr_data,
   output int                   fail_count,
   output int                   pending_count,
   output int                   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  count;
      logic [COUNT_W-1:0]  capacity;
   } vector_result_type;

   vector_result_type expected_results[$];
   logic [VALUE_W-1:0] handle_mem [0:DEPTH-1];
   int unsigned elem_count;
   int unsigned cap_now;
   int unsigned init_cap_reg;
   int unsigned block_reg;

   initial begin
      fail_count = 0;
      pending_count = 0;
      checked_count = 0;
   end

   function automatic int unsigned shrink_floor();
      return (init_cap_reg > DEPTH) ? DEPTH : init_cap_reg;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
      if (idx == CSR_INIT_CAP) begin
         init_cap_reg = 32'(data);
         elem_count = 0;
         cap_now = shrink_floor();
      end else if (idx == CSR_BLOCK_SIZE) begin
         block_reg = 32'(data);
      end
   endfunction

   function automatic vector_result_type predict_vector_op(logic [KIND_W-1:0] kind,
                                                           logic [INDEX_W-1:0] idx,
                                                           logic [VALUE_W-1:0] val);
      vector_result_type r;
      r.status = ST_OK;
      r.read_value = '0;
      case (kind)
         KIND_APPEND: begin
            if (val == '0) begin
               r.status = ST_INVALID;
            end else if (elem_count >= cap_now && block_reg == 0) begin
               r.status = ST_FIXED;
            end else if (elem_count >= cap_now && cap_now + block_reg > DEPTH) begin
               r.status = ST_ALLOC;
            end else begin
               if (elem_count >= cap_now) cap_now += block_reg;
               if (elem_count < DEPTH) begin
                  handle_mem[elem_count] = val;
                  elem_count++;
               end else begin
                  r.status = ST_ALLOC;
               end
            end
         end
         KIND_REMOVE: begin
            if (elem_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               elem_count--;
               r.read_value = handle_mem[elem_count];
               if (block_reg > 0 && cap_now > shrink_floor() &&
                   cap_now - elem_count >= 2 * block_reg)
                  cap_now -= block_reg;
            end
         end
         KIND_GET: begin
            if (idx >= elem_count) r.status = ST_BOUNDS;
            else r.read_value = handle_mem[idx];
         end
         KIND_SET: begin
            if (idx >= elem_count) r.status = ST_BOUNDS;
            else handle_mem[idx] = val;
         end
         KIND_QUERY: begin
         end
         default: begin
            r.status = ST_INVALID;
         end
      endcase
      r.count = elem_count[COUNT_W-1:0];
      r.capacity = cap_now[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      vector_result_type seen;
      vector_result_type want;
      seen = {rsp_status, rsp_read_value, rsp_element_count, rsp_current_capacity};
      if (reset) begin
         expected_results.delete();
         init_cap_reg = 32'(RESET_INIT_CAP);
         block_reg = 32'(RESET_BLOCK_SIZE);
         elem_count = 0;
         cap_now = shrink_floor();
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && !req_stall)
            expected_results.push_back(predict_vector_op(req_kind, req_index, req_value));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with none expected, got status %0d read %h",
                        $time, seen.status, seen.read_value);
               $display("%0t:    count %0d cap %0d", $time, seen.count, seen.capacity);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (seen !== want) begin
                  $display("%0t: expected status %0d read %h count %0d cap %0d,",
                           $time, want.status, want.read_value, want.count, want.capacity);
                  $display("%0t:    got status %0d read %h count %0d cap %0d",
                           $time, seen.status, seen.read_value, seen.count, seen.capacity);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

[tb/testbench.sv]
// Top of the growable stack vector testbench: clock, reset, stimulus, stall pattern and verdict.
module testbench
   import gsv_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {MIX_GROW, MIX_DRAIN, MIX_ACCESS} op_mix_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind = KIND_QUERY;
   logic [INDEX_W-1:0]   req_index = '0;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [VALUE_W-1:0]   rsp_read_value;
   logic [COUNT_W-1:0]   rsp_element_count;
   logic [COUNT_W-1:0]   rsp_current_capacity;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_INIT_CAP;
   logic [COUNT_W-1:0]   csr_data = '0;
   int                   fail_count;
   int                   pending_count;
   int                   checked_count;

   int unsigned sent_count = 0;
   int unsigned csr_count = 0;
   int unsigned burst_left = 0;
   int unsigned fill_guess = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_hold = 0;

   growable_stack_vector i_dut (.*);

   gsv_checker i_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_hold = $urandom_range(20, 150);
      end else begin
         stall_hold--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic send_req(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] ix, logic [VALUE_W-1:0] v);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= k;
      req_index <= ix;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if (k == KIND_APPEND && v != '0 && fill_guess < 256) fill_guess++;
      if (k == KIND_REMOVE && fill_guess > 0) fill_guess--;
   endtask

   // The block is drained and left to settle before any register transfer.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_count++;
      if (idx == CSR_INIT_CAP) fill_guess = 0;
   endtask

   task automatic set_vector_config(logic [COUNT_W-1:0] init_cap, logic [COUNT_W-1:0] blk);
      write_csr(CSR_BLOCK_SIZE, blk);
      write_csr(CSR_INIT_CAP, init_cap);
   endtask

   task automatic run_phase(int unsigned count);
      op_mix_type mix;
      int unsigned seg_left;
      int unsigned fill_len;
      int unsigned app_pct;
      int unsigned rem_pct;
      int unsigned r;
      logic [KIND_W-1:0] k;
      logic [INDEX_W-1:0] ix;
      logic [VALUE_W-1:0] v;
      seg_left = 0;
      mix = MIX_GROW;
      fill_len = (count > 100) ? count - 40 : count / 2;
      for (int unsigned n = 0; n < count; n++) begin
         if (n < fill_len) begin
            mix = MIX_GROW;
         end else if (seg_left == 0) begin
            mix = op_mix_type'($urandom_range(0, 2));
            seg_left = $urandom_range(8, 40);
         end else begin
            seg_left--;
         end
         case (mix)
            MIX_GROW: begin app_pct = 90; rem_pct = 3; end
            MIX_DRAIN: begin app_pct = 15; rem_pct = 65; end
            default: begin app_pct = 25; rem_pct = 10; end
         endcase
         v = $urandom;
         if ($urandom_range(0, 15) == 0) v = 32'hFFFF_FFFF;
         if ($urandom_range(0, 4) == 0) ix = INDEX_W'($urandom_range(0, 255));
         else ix = (fill_guess > 255) ? INDEX_W'($urandom_range(0, 255))
                                      : INDEX_W'($urandom_range(0, fill_guess));
         r = $urandom_range(0, 99);
         if (r < app_pct) begin
            k = KIND_APPEND;
         end else if (r < app_pct + rem_pct) begin
            k = KIND_REMOVE;
         end else if (r < app_pct + rem_pct + 2) begin
            k = KIND_W'($urandom_range(5, 7));
         end else if (r < app_pct + rem_pct + 4) begin
            k = KIND_APPEND;
            v = '0;
         end else begin
            case ($urandom_range(0, 4))
               0, 1: k = KIND_GET;
               2, 3: k = KIND_SET;
               default: k = KIND_QUERY;
            endcase
         end
         send_req(k, ix, v);
      end
   endtask

   initial begin
      int unsigned init_tab [10] = '{8, 0, 256, 0, 511, 1, 0, 16, 250, 5};
      int unsigned blk_tab [10] = '{8, 1, 0, 0, 4, 256, 256, 3, 8, 511};
      int unsigned len_tab [10] = '{80, 100, 360, 30, 360, 60, 60, 60, 360, 60};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_req(KIND_QUERY, 8'd0, 32'd0);
      send_req(KIND_REMOVE, 8'd0, 32'd0);
      send_req(KIND_GET, 8'd0, 32'd0);
      send_req(KIND_SET, 8'd255, 32'h1234_5678);
      send_req(KIND_APPEND, 8'd0, 32'd0);
      send_req(KIND_APPEND, 8'd0, 32'hFFFF_FFFF);
      send_req(KIND_APPEND, 8'hFF, 32'h0000_0001);
      send_req(KIND_GET, 8'd1, 32'd0);
      send_req(KIND_GET, 8'd255, 32'd0);
      send_req(KIND_SET, 8'd0, 32'd0);
      send_req(KIND_GET, 8'd0, 32'hFFFF_FFFF);
      send_req(3'd5, 8'd0, 32'd0);
      send_req(3'd6, 8'hFF, 32'hFFFF_FFFF);
      send_req(3'd7, 8'd0, 32'd1);
      send_req(KIND_REMOVE, 8'd0, 32'd0);
      send_req(KIND_REMOVE, 8'd0, 32'd0);
      send_req(KIND_REMOVE, 8'd0, 32'd0);
      set_vector_config(9'd2, 9'd0);
      send_req(KIND_APPEND, 8'd0, 32'hA5A5_A5A5);
      send_req(KIND_APPEND, 8'd0, 32'h5A5A_5A5A);
      send_req(KIND_APPEND, 8'd0, 32'h0F0F_0F0F);
      set_vector_config(9'd0, 9'd0);
      send_req(KIND_APPEND, 8'd0, 32'h8000_0000);
      send_req(KIND_QUERY, 8'd0, 32'd0);
      set_vector_config(9'd0, 9'd256);
      send_req(KIND_APPEND, 8'd0, 32'h7FFF_FFFF);
      send_req(KIND_REMOVE, 8'd0, 32'd0);
      send_req(KIND_QUERY, 8'd0, 32'd0);

      for (int p = 0; p < 10; p++) begin
         set_vector_config(COUNT_W'(init_tab[p]), COUNT_W'(blk_tab[p]));
         run_phase(len_tab[p]);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d requests under %0d register transfers; %0d results compared.",
               sent_count, csr_count, checked_count);
      $display("Covered fixed, growing, shrinking and full vectors, bounds and invalid requests.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("[growable_stack_vector] OK");
      end else begin
         $display("[growable_stack_vector] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", pending_count);
      $display("[growable_stack_vector] ERROR");
      $finish;
   end

endmodule
